FILE: rtl/mt44_pkg.sv
package mt44_pkg;

  localparam int TILE   = 4;
  localparam int DATA_W = 16;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ROW_W  = $clog2(TILE);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [ROW_W-1:0]         row_t;

  // control from the step register to the accumulator array
  typedef struct packed {
    logic en;   // add this step's products
    logic clr;  // tile done: clear instead of keeping the sums
  } acc_ctl_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam row_t LAST_ROW = row_t'(TILE - 1);

  // saturating add of one exact product into an accumulator
  function automatic acc_t sat_add(acc_t acc, prod_t p);
    logic signed [ACC_W:0] s;
    acc_t res;
    s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){p[PROD_W-1]}}, p};
    if (s[ACC_W] != s[ACC_W-1]) begin
      res = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      res = s[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/mt44_acc_array.sv
module mt44_acc_array
  import mt44_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  acc_ctl_t ctl,
  input  data_t    a [TILE],
  input  data_t    b [TILE],
  output acc_t     sum_next [TILE][TILE]
);

  acc_t acc [TILE][TILE];

  for (genvar r = 0; r < TILE; r++) begin : g_row
    for (genvar c = 0; c < TILE; c++) begin : g_col
      prod_t prod;

      // Q8.8 x Q8.8 -> exact Q16.16
      assign prod = a[r] * b[c];
      assign sum_next[r][c] = sat_add(acc[r][c], prod);

      always_ff @(posedge clk) begin
        if (rst) begin
          acc[r][c] <= '0;
        end else if (ctl.en) begin
          acc[r][c] <= ctl.clr ? acc_t'(0) : sum_next[r][c];
        end
      end
    end
  end

endmodule

FILE: rtl/matmul_tile_4x4_outer_product_unit.sv
// Flow: an accepted item waits in the step register until its products are added;
//   on a last step row 0 of the tile is offered; rows 1..3 follow, one per accepted output.
// Throughput: one step per cycle. A tile drains its four rows through the single
//   result register bank, so a tile shorter than four steps waits for that drain.
// Reset (rst, synchronous, active high): accumulators cleared, no item held,
//   no result offered.
module matmul_tile_4x4_outer_product_unit
  import mt44_pkg::*;
(
  input  logic  clk,
  input  logic  rst,

  input  logic  in_valid,
  output logic  in_ready,
  input  data_t a_row0,
  input  data_t a_row1,
  input  data_t a_row2,
  input  data_t a_row3,
  input  data_t b_col0,
  input  data_t b_col1,
  input  data_t b_col2,
  input  data_t b_col3,
  input  logic  last_step,

  output logic  out_valid,
  input  logic  out_ready,
  output row_t  tile_row,
  output acc_t  sum_col0,
  output acc_t  sum_col1,
  output acc_t  sum_col2,
  output acc_t  sum_col3,
  output logic  last_row
);

  // ---------------------------------------------------------------------------
  // Step register: holds one accepted item until its products are added.
  // ---------------------------------------------------------------------------
  logic  step_valid;
  logic  step_last;
  data_t step_a [TILE];
  data_t step_b [TILE];

  // ---------------------------------------------------------------------------
  // Tile buffer: finished C tile, drained one row per output item.
  // ---------------------------------------------------------------------------
  logic  tile_valid;
  row_t  tile_ptr;
  acc_t  tile_buf [TILE][TILE];

  acc_t     sum_next [TILE][TILE];
  acc_ctl_t ctl;
  logic     tile_free;
  logic     step_adv;
  logic     in_take;
  logic     out_take;

  assign out_take  = out_valid && out_ready;
  // buffer is free now, or its last row leaves this cycle
  assign tile_free = !tile_valid || (out_take && (tile_ptr == LAST_ROW));
  // a plain step always retires; a last step needs room for its tile
  assign step_adv  = step_valid && (!step_last || tile_free);
  assign in_ready  = !step_valid || step_adv;
  assign in_take   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (in_take) begin
      step_valid <= 1'b1;
    end else if (step_adv) begin
      step_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      step_last <= last_step;
      step_a[0] <= a_row0;
      step_a[1] <= a_row1;
      step_a[2] <= a_row2;
      step_a[3] <= a_row3;
      step_b[0] <= b_col0;
      step_b[1] <= b_col1;
      step_b[2] <= b_col2;
      step_b[3] <= b_col3;
    end
  end

  // sixteen saturating MACs; cleared in the same edge the tile is captured
  assign ctl.en  = step_adv;
  assign ctl.clr = step_last;

  mt44_acc_array u_acc (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .a        (step_a),
    .b        (step_b),
    .sum_next (sum_next)
  );

  logic capture;
  assign capture = step_adv && step_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_valid <= 1'b0;
      tile_ptr   <= '0;
    end else if (capture) begin
      tile_valid <= 1'b1;
      tile_ptr   <= '0;
    end else if (out_take) begin
      if (tile_ptr == LAST_ROW) begin
        tile_valid <= 1'b0;
      end
      tile_ptr <= tile_ptr + row_t'(1);
    end
  end

  // includes this step's products, as the tile is C = sum over all steps
  always_ff @(posedge clk) begin
    if (capture) begin
      tile_buf <= sum_next;
    end
  end

  assign out_valid = tile_valid;
  assign tile_row  = tile_ptr;
  assign sum_col0  = tile_buf[tile_ptr][0];
  assign sum_col1  = tile_buf[tile_ptr][1];
  assign sum_col2  = tile_buf[tile_ptr][2];
  assign sum_col3  = tile_buf[tile_ptr][3];
  assign last_row  = (tile_ptr == LAST_ROW);

endmodule

FILE: rtl/mt44_checker.sv
module mt44_checker
  import mt44_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input row_t tile_row,
  input acc_t sum_col0,
  input logic last_row
);

  // nothing offered straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // a tile always starts on row 0
  a_first_row: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (tile_row == row_t'(0)))
    else $error("tile did not start on row 0");

  // rows of one tile come back to back in order
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row) |=>
      (out_valid && (tile_row == $past(tile_row) + row_t'(1))))
    else $error("tile rows out of order or broken");

  // last_row flags exactly the final row
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (tile_row == LAST_ROW)))
    else $error("last_row mismatch");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(tile_row) && $stable(sum_col0)))
    else $error("stalled result changed");

endmodule

bind matmul_tile_4x4_outer_product_unit mt44_checker u_mt44_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .tile_row  (tile_row),
  .sum_col0  (sum_col0),
  .last_row  (last_row)
);

FILE: tb/matmul_tile_4x4_outer_product_unit_test.sv
module matmul_tile_4x4_outer_product_unit_test;
  import mt44_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One inner-dimension step: a column of A, a row of B, end-of-tile mark.
  typedef struct {
    data_t a[TILE];
    data_t b[TILE];
    logic  last;
  } step_t;

  // One row of the C tile as the block should present it.
  typedef struct {
    row_t row;
    acc_t sum[TILE];
    logic last;
  } c_row_t;

  // Running C tile: sixteen saturating Q32.16 sums, plus the rows that are
  // owed to the output once a tile closes.
  class tile_sums;
    acc_t   acc[TILE*TILE];
    c_row_t rows_due[$];
    int     errors;

    function new();
      foreach (acc[i]) acc[i] = '0;
      errors = 0;
    endfunction

    task report(string msg);
      // keep the log readable if the block is badly off
      if (errors < 60) $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    // Fold one accepted step into the sums; on a last step queue the four
    // rows and start a fresh tile.
    function void add_step(step_t s);
      longint sum;
      c_row_t r;
      for (int i = 0; i < TILE; i++) begin
        for (int j = 0; j < TILE; j++) begin
          sum = longint'(acc[i*TILE+j]) + longint'(s.a[i]) * longint'(s.b[j]);
          if (sum > longint'(ACC_MAX)) begin
            acc[i*TILE+j] = ACC_MAX;
          end else if (sum < longint'(ACC_MIN)) begin
            acc[i*TILE+j] = ACC_MIN;
          end else begin
            acc[i*TILE+j] = acc_t'(sum);
          end
        end
      end
      if (s.last) begin
        for (int i = 0; i < TILE; i++) begin
          r.row = row_t'(i);
          for (int j = 0; j < TILE; j++) r.sum[j] = acc[i*TILE+j];
          r.last = (i == TILE - 1);
          rows_due.push_back(r);
        end
        foreach (acc[i]) acc[i] = '0;
      end
    endfunction

    task check_row(c_row_t got);
      c_row_t want;
      if (rows_due.size() == 0) begin
        report($sformatf("row %0d arrived with no tile pending", got.row));
      end else begin
        want = rows_due.pop_front();
        if (got.row !== want.row)
          report($sformatf("tile_row got %0d want %0d", got.row, want.row));
        for (int j = 0; j < TILE; j++) begin
          if (got.sum[j] !== want.sum[j])
            report($sformatf("row %0d col %0d got %0d want %0d",
                             want.row, j, got.sum[j], want.sum[j]));
        end
        if (got.last !== want.last)
          report($sformatf("row %0d last_row got %b want %b",
                           want.row, got.last, want.last));
      end
    endtask

    function int pending();
      return rows_due.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;   // cycles with no item moving either way
  localparam int RAND_STEPS  = 215;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  data_t a_row0 = '0, a_row1 = '0, a_row2 = '0, a_row3 = '0;
  data_t b_col0 = '0, b_col1 = '0, b_col2 = '0, b_col3 = '0;
  logic  last_step = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  row_t  tile_row;
  acc_t  sum_col0, sum_col1, sum_col2, sum_col3;
  logic  last_row;

  logic  steady = 1'b0;   // high: neither side idles
  int    stall_cycles = 0;

  tile_sums tile = new();

  matmul_tile_4x4_outer_product_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_row0    (a_row0),
    .a_row1    (a_row1),
    .a_row2    (a_row2),
    .a_row3    (a_row3),
    .b_col0    (b_col0),
    .b_col1    (b_col1),
    .b_col2    (b_col2),
    .b_col3    (b_col3),
    .last_step (last_step),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tile_row  (tile_row),
    .sum_col0  (sum_col0),
    .sum_col1  (sum_col1),
    .sum_col2  (sum_col2),
    .sum_col3  (sum_col3),
    .last_row  (last_row)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side backpressure: ready drops in about a third of the cycles.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 32);
  end

  // Input monitor: every accepted item goes into the running tile.
  always @(posedge clk) begin
    step_t s;
    if (!rst && in_valid && in_ready) begin
      s.a[0] = a_row0; s.a[1] = a_row1; s.a[2] = a_row2; s.a[3] = a_row3;
      s.b[0] = b_col0; s.b[1] = b_col1; s.b[2] = b_col2; s.b[3] = b_col3;
      s.last = last_step;
      tile.add_step(s);
    end
  end

  // Output monitor: each accepted row is checked against the oldest one due.
  always @(posedge clk) begin
    c_row_t r;
    if (!rst && out_valid && out_ready) begin
      r.row = tile_row;
      r.sum[0] = sum_col0; r.sum[1] = sum_col1;
      r.sum[2] = sum_col2; r.sum[3] = sum_col3;
      r.last = last_row;
      tile.check_row(r);
    end
  end

  // Watchdog: a hung handshake ends the run. Rows nobody is waiting for
  // do not count as progress, so a runaway output cannot keep it alive.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready && tile.pending() != 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic step_t mk_step(data_t a0, data_t a1, data_t a2, data_t a3,
                                    data_t b0, data_t b1, data_t b2, data_t b3,
                                    logic last);
    step_t s;
    s.a[0] = a0; s.a[1] = a1; s.a[2] = a2; s.a[3] = a3;
    s.b[0] = b0; s.b[1] = b1; s.b[2] = b2; s.b[3] = b3;
    s.last = last;
    return s;
  endfunction

  // Full-range random values half the time, the corners the other half.
  function automatic data_t pick_value();
    data_t v;
    case ($urandom_range(7))
      0:       v = 16'sh8000;
      1:       v = 16'sh7fff;
      2:       v = '0;
      3:       v = '1;
      default: v = data_t'($urandom);
    endcase
    return v;
  endfunction

  // Present one item and hold it until accepted. Called at a rising edge;
  // valid is only lowered for a random gap, never dropped and re-raised in
  // the same step.
  task send_step(step_t s);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    a_row0    <= s.a[0]; a_row1 <= s.a[1]; a_row2 <= s.a[2]; a_row3 <= s.a[3];
    b_col0    <= s.b[0]; b_col1 <= s.b[1]; b_col2 <= s.b[2]; b_col3 <= s.b[3];
    last_step <= s.last;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int    sent;
    int    len;
    step_t s;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-step tiles at the corners of the Q8.8 range.
    send_step(mk_step(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                      16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1));
    send_step(mk_step(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1));
    send_step(mk_step(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001,
                      16'sh8000, 16'sh7fff, 16'shffff, 16'sh0000, 1'b1));
    send_step(mk_step('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));

    // Multi-step tiles: mixed signs, then some that cancel.
    send_step(mk_step(16'sh0100, 16'shff00, 16'sh0080, 16'sh8000,
                      16'sh0200, 16'sh7fff, 16'shfe00, 16'sh0001, 1'b0));
    send_step(mk_step(16'shffff, 16'sh0001, 16'sh7fff, 16'sh8000,
                      16'sh8000, 16'shffff, 16'sh0001, 16'sh7fff, 1'b0));
    send_step(mk_step(16'sh5555, 16'shaaaa, 16'sh3333, 16'shcccc,
                      16'shaaaa, 16'sh5555, 16'shcccc, 16'sh3333, 1'b1));
    send_step(mk_step(16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234,
                      16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 1'b0));
    send_step(mk_step(16'shedcc, 16'shedcc, 16'shedcc, 16'shedcc,
                      16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 1'b1));
    // Back-to-back short tiles force the row drain to hold off input.
    for (int k = 0; k < 8; k++) begin
      send_step(mk_step(pick_value(), pick_value(), pick_value(), pick_value(),
                        pick_value(), pick_value(), pick_value(), pick_value(),
                        k[0]));
    end

    // Random tiles, mostly short, a few long; one stretch with no idling.
    sent = 0;
    while (sent < RAND_STEPS) begin
      steady <= (sent >= 90 && sent < 150);
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        s = mk_step(pick_value(), pick_value(), pick_value(), pick_value(),
                    pick_value(), pick_value(), pick_value(), pick_value(),
                    k == len - 1);
        send_step(s);
        sent++;
      end
    end
    in_valid  <= 1'b0;
    steady    <= 1'b0;

    // Drain the last tile's rows, then let the pipeline settle before the verdict.
    while (tile.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tile.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mt44_pkg.sv
rtl/mt44_acc_array.sv
rtl/matmul_tile_4x4_outer_product_unit.sv
rtl/mt44_checker.sv
tb/matmul_tile_4x4_outer_product_unit_test.sv
